>>> rtl/lkv_pkg.sv
// Shared types and constants for the LRU key-value cache.
// No dependencies; compile first.
`default_nettype none
package lkv_pkg;

  localparam int MODE_W = 2;
  localparam int KEY_W  = 32;
  localparam int VAL_W  = 32;
  localparam int CAP_W  = 7;
  localparam int OCC_W  = 7;
  localparam int CNT_W  = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [MODE_W-1:0] {
    MODE_GET   = 2'd0,
    MODE_PUT   = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture request beat
    logic look;    // register lookup results, read value store
    logic commit;  // apply update, load response register
  } cmd_t;

endpackage
`default_nettype wire

>>> rtl/lkv_if.sv
// Channel interfaces for the LRU key-value cache: request, response, config.
// Depends on lkv_pkg.
`default_nettype none
interface lkv_req_if;
  logic                      valid;
  logic                      ready;
  logic [lkv_pkg::MODE_W-1:0] mode;
  logic [lkv_pkg::KEY_W-1:0]  lookup_key;
  logic [lkv_pkg::VAL_W-1:0]  write_value;
  modport source (output valid, mode, lookup_key, write_value, input ready);
  modport sink   (input valid, mode, lookup_key, write_value, output ready);
endinterface

interface lkv_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      hit;
  logic [lkv_pkg::VAL_W-1:0] read_value;
  logic [lkv_pkg::OCC_W-1:0] occupancy;
  logic [lkv_pkg::CNT_W-1:0] hit_total;
  logic [lkv_pkg::CNT_W-1:0] miss_total;
  modport source (output valid, hit, read_value, occupancy, hit_total, miss_total,
                  input ready);
  modport sink   (input valid, hit, read_value, occupancy, hit_total, miss_total,
                  output ready);
endinterface

interface lkv_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [lkv_pkg::CAP_W-1:0] capacity_in_use;
  modport source (output valid, capacity_in_use, input ready);
  modport sink   (input valid, capacity_in_use, output ready);
endinterface
`default_nettype wire

>>> rtl/lkv_ctrl.sv
// Controller for the LRU key-value cache: sequences lookup and update,
// owns the response valid. Depends on lkv_pkg.
`default_nettype none
module lkv_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output lkv_pkg::cmd_t      cmd
);
  import lkv_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_UPD} state_t;

  state_t state;
  logic   go;

  // update may retire once the response register is free
  assign go       = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) || ((state == S_UPD) && go);

  assign cmd.load   = in_valid && in_ready;
  assign cmd.look   = (state == S_LOOK);
  assign cmd.commit = (state == S_UPD) && go;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.load) state <= S_LOOK;
        end
        S_LOOK: state <= S_UPD;
        S_UPD: begin
          if (cmd.load)      state <= S_LOOK;
          else if (go)       state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid) else $error("response not raised after update");
  a_load_look: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == S_LOOK)) else $error("accepted beat not looked up");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD) && out_valid && !out_ready |=> (state == S_UPD))
    else $error("update retired over pending response");
`endif
endmodule
`default_nettype wire

>>> rtl/lkv_dp.sv
// Datapath for the LRU key-value cache: key and rank registers, value store,
// counters, capacity register, response payload. Depends on lkv_pkg.
`default_nettype none
module lkv_dp #(
  parameter int ENTRIES = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire lkv_pkg::cmd_t             cmd,
  input  wire logic [lkv_pkg::MODE_W-1:0] mode,
  input  wire logic [lkv_pkg::KEY_W-1:0]  lookup_key,
  input  wire logic [lkv_pkg::VAL_W-1:0]  write_value,
  input  wire logic                      cap_we,
  input  wire logic [lkv_pkg::CAP_W-1:0]  cap_data,
  output logic                           hit,
  output logic [lkv_pkg::VAL_W-1:0]       read_value,
  output logic [lkv_pkg::OCC_W-1:0]       occupancy,
  output logic [lkv_pkg::CNT_W-1:0]       hit_total,
  output logic [lkv_pkg::CNT_W-1:0]       miss_total
);
  import lkv_pkg::*;

  localparam int RW   = $clog2(ENTRIES);
  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

  // entry state
  logic [KEY_W-1:0] keys  [ENTRIES];
  logic [RW-1:0]    rank  [ENTRIES];
  logic [ENTRIES-1:0] valid;
  logic [VAL_W-1:0] vmem  [ENTRIES];
  logic [CW-1:0]    count;
  logic [CNT_W-1:0] hits, misses;
  logic [CAP_W-1:0] cap;

  // captured request
  mode_t            mode_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;

  // lookup stage
  logic [ENTRIES-1:0] match, victim;
  logic [RW-1:0]      hidx_c, hrank_c, last_rank;
  logic [CMPW-1:0]    capx, eff;
  logic               evict_c;

  logic               hit_r, evict_r;
  logic [RW-1:0]      hit_idx, hit_rank;
  logic [ENTRIES-1:0] victim_r;
  logic [VAL_W-1:0]   rd_data;

  // update stage
  logic [ENTRIES-1:0] va;
  logic [RW-1:0]      free_idx;
  logic               free_any;
  logic               is_hit_op;

  assign last_rank = RW'(count - CW'(1));

  always_comb begin
    hidx_c  = '0;
    hrank_c = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]  = valid[i] && (keys[i] == key_r);
      victim[i] = valid[i] && (rank[i] == last_rank);
      if (match[i]) begin
        hidx_c  = hidx_c | RW'(i);
        hrank_c = hrank_c | rank[i];
      end
    end
  end

  always_comb begin
    capx = CMPW'(cap);
    if (cap == '0)                    eff = CMPW'(1);
    else if (capx > CMPW'(ENTRIES))   eff = CMPW'(ENTRIES);
    else                              eff = capx;
    evict_c = (CMPW'(count) >= eff) && (count != '0);
  end

  // free slot after a possible eviction, lowest index first
  always_comb begin
    va       = valid & ~(evict_r ? victim_r : '0);
    free_any = ~&va;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!va[i]) free_idx = RW'(i);
    end
  end

  assign is_hit_op = (mode_r == MODE_GET) || (mode_r == MODE_PUT);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= mode_t'(mode);
      key_r  <= lookup_key;
      val_r  <= write_value;
    end
    if (cmd.look) begin
      hit_r    <= |match;
      hit_idx  <= hidx_c;
      hit_rank <= hrank_c;
      victim_r <= victim;
      evict_r  <= evict_c;
    end
    if (cmd.commit) begin
      hit        <= hit_r && is_hit_op;
      read_value <= (hit_r && (mode_r == MODE_GET)) ? rd_data : '0;
    end
    if (cmd.commit && (mode_r == MODE_PUT) && !hit_r && free_any) begin
      keys[free_idx] <= key_r;
    end
  end

  // value store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.look) begin
      rd_data <= vmem[hidx_c];
    end
    if (cmd.commit && (mode_r == MODE_PUT) && (hit_r || free_any)) begin
      vmem[hit_r ? hit_idx : free_idx] <= val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      count  <= '0;
      hits   <= '0;
      misses <= '0;
      cap    <= CAP_RESET;
      for (int i = 0; i < ENTRIES; i++) rank[i] <= '0;
    end else begin
      if (cap_we) cap <= cap_data;
      if (cmd.commit) begin
        case (mode_r)
          MODE_GET, MODE_PUT: begin
            if (hit_r) begin
              for (int i = 0; i < ENTRIES; i++) begin
                if (valid[i] && (RW'(i) != hit_idx) && (rank[i] < hit_rank))
                  rank[i] <= rank[i] + RW'(1);
              end
              rank[hit_idx] <= '0;
              if ((mode_r == MODE_GET) && (hits != '1)) hits <= hits + CNT_W'(1);
            end else if (mode_r == MODE_GET) begin
              if (misses != '1) misses <= misses + CNT_W'(1);
            end else begin
              // put miss: drop victim if at capacity, insert as most recent
              valid <= va | (free_any ? (ENTRIES'(1) << free_idx) : '0);
              count <= count - CW'(evict_r) + CW'(free_any);
              for (int i = 0; i < ENTRIES; i++) begin
                if (va[i]) rank[i] <= rank[i] + RW'(1);
              end
              if (free_any) rank[free_idx] <= '0;
            end
          end
          MODE_CLEAR: begin
            valid <= '0;
            count <= '0;
            for (int i = 0; i < ENTRIES; i++) rank[i] <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  assign occupancy  = OCC_W'(count);
  assign hit_total  = hits;
  assign miss_total = misses;

`ifndef SYNTHESIS
  a_key_unique: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match)) else $error("key held in more than one entry");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(ENTRIES)) else $error("occupancy beyond entry count");
  a_put_fills: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && (mode_r == MODE_PUT) |=> (count != '0))
    else $error("store empty after put");
`endif
endmodule
`default_nettype wire

>>> rtl/lru_key_value_cache.sv
// LRU key-value cache top level: controller plus datapath.
// Each request beat takes a lookup step (parallel key compare, value
// store read), then an update step that loads the response and waits
// on a held response. The next beat is accepted as an update retires.
// Synchronous reset empties the store, zeroes counters, capacity 64.
// Depends on lkv_pkg, lkv_if, lkv_ctrl, lkv_dp.
`default_nettype none
module lru_key_value_cache #(
  parameter int ENTRIES = 64
) (
  input wire logic  clk,
  input wire logic  rst,
  lkv_req_if.sink   req,
  lkv_rsp_if.source rsp,
  lkv_cfg_if.sink   cfg
);
  import lkv_pkg::*;

  cmd_t cmd;

  assign cfg.ready = 1'b1;

  lkv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  lkv_dp #(.ENTRIES(ENTRIES)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .mode        (req.mode),
    .lookup_key  (req.lookup_key),
    .write_value (req.write_value),
    .cap_we      (cfg.valid),
    .cap_data    (cfg.capacity_in_use),
    .hit         (rsp.hit),
    .read_value  (rsp.read_value),
    .occupancy   (rsp.occupancy),
    .hit_total   (rsp.hit_total),
    .miss_total  (rsp.miss_total)
  );

endmodule
`default_nettype wire
